### src/grrs_pkg.sv
// shared types and constants of the grouped round-robin task scheduler
package grrs_pkg;

	localparam int CONTAINERS_DEF = 16;
	localparam int TASKS_DEF      = 16;
	localparam int KEY_W          = 16;
	localparam int TID_W          = 22;

	localparam logic [1:0] CMD_CREATE = 2'd0;
	localparam logic [1:0] CMD_LEAVE  = 2'd1;
	localparam logic [1:0] CMD_SWITCH = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_TABLE_FULL = 2'd1;
	localparam logic [1:0] ST_QUEUE_FULL = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

	typedef struct packed {
		logic [1:0]       command;
		logic [KEY_W-1:0] container_id;
		logic [TID_W-1:0] caller_tid;
	} req_t;

	typedef struct packed {
		logic             wake_valid;
		logic [TID_W-1:0] wake_tid;
		logic             caller_sleeps;
		logic [1:0]       status;
		logic             last;
	} res_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_SCAN, OP_ALLOC, OP_APPEND, OP_EMIT,
		OP_LV_RD, OP_LV_CMP, OP_DROP_SCAN, OP_DROP_FIN,
		OP_RO_RD, OP_RO_WR, OP_SH_RD, OP_SH_WR, OP_LEN_DEC,
		OP_HD_RD, OP_HD_EMIT,
		OP_SW_INIT, OP_SW_RH, OP_SW_R2, OP_SW_CHK, OP_SW_ADV,
		OP_SW2_INIT, OP_SW2_RD, OP_SW2_CHK, OP_SW_END
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] status;
	} ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       found;
		logic       free_ok;
		logic       scan_last;
		logic       total_full;
		logic       total_zero;
		logic       len_zero;
		logic       len_one;
		logic       len_ge2;
		logic       len_full;
		logic       hit;
		logic       p_last;
		logic       p_more;
		logic       sh_more;
		logic       drop_hit;
		logic       n_done;
	} stat_t;

endpackage

### src/grrs_datapath.sv
// tables, queue memory and result register of the scheduler
module grrs_datapath import grrs_pkg::*; #(
	parameter int CONTAINERS = CONTAINERS_DEF,
	parameter int TASKS      = TASKS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  request,
	input  ctl_t  ctl,
	output stat_t stat,
	output res_t  result,
	output logic  result_valid
);

	localparam int SW    = (CONTAINERS > 1) ? $clog2(CONTAINERS) : 1;
	localparam int TW    = (TASKS > 1) ? $clog2(TASKS) : 1;
	localparam int LW    = $clog2(TASKS + 1);
	localparam int NW    = $clog2(CONTAINERS + 1);
	localparam int DEPTH = CONTAINERS * TASKS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [1:0]       cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [TID_W-1:0] tid_q;

	logic [CONTAINERS-1:0] used_q;
	logic [KEY_W-1:0]      key_tab_q [CONTAINERS];
	logic [SW-1:0]         next_q    [CONTAINERS];
	logic [TW-1:0]         front_q   [CONTAINERS];
	logic [LW-1:0]         len_q     [CONTAINERS];
	logic [SW-1:0]         newest_q;
	logic [NW-1:0]         total_q;

	logic [SW-1:0]    sidx_q, s_q, free_q;
	logic             found_q, free_ok_q;
	logic [LW-1:0]    p_q;
	logic [NW-1:0]    n_q;
	logic [TID_W-1:0] head_q, pend_tid_q;
	logic             pend_q, runs_q;

	logic [TID_W-1:0] mem [DEPTH];
	logic [TID_W-1:0] rdata_q;
	res_t             result_q;
	logic             rvalid_q;

	logic [LW-1:0]    cur_len;
	logic [TW-1:0]    cur_front, finc;
	logic [TW:0]      fsum;
	logic             rd_en, wr_en, emit, drop_hit, sw_wake;
	logic [AW-1:0]    raddr, waddr;
	logic [TID_W-1:0] wdata;
	res_t             res_d;

	// address of queue entry i of slot s, counted from the front
	function automatic logic [AW-1:0] qaddr(input logic [SW-1:0] s,
	                                        input logic [TW-1:0] f,
	                                        input logic [LW-1:0] i);
		logic [LW:0] sum;
		sum = (LW+1)'(f) + (LW+1)'(i);
		if (sum >= (LW+1)'(TASKS)) sum = sum - (LW+1)'(TASKS);
		return AW'(s) * AW'(TASKS) + AW'(sum);
	endfunction

	assign cur_len   = len_q[s_q];
	assign cur_front = front_q[s_q];
	assign fsum      = (TW+1)'(cur_front) + (TW+1)'(1);
	assign finc      = (fsum == (TW+1)'(TASKS)) ? '0 : fsum[TW-1:0];
	assign drop_hit  = used_q[sidx_q] && (sidx_q != s_q) && (next_q[sidx_q] == s_q);
	assign sw_wake   = (rdata_q != head_q) && (rdata_q != tid_q);

	always_comb begin
		stat.cmd        = cmd_q;
		stat.found      = found_q;
		stat.free_ok    = free_ok_q;
		stat.scan_last  = (sidx_q == SW'(CONTAINERS - 1));
		stat.total_full = (total_q >= NW'(CONTAINERS));
		stat.total_zero = (total_q == '0);
		stat.len_zero   = (cur_len == '0);
		stat.len_one    = (cur_len == LW'(1));
		stat.len_ge2    = (cur_len >= LW'(2));
		stat.len_full   = (cur_len >= LW'(TASKS));
		stat.hit        = (rdata_q == tid_q);
		stat.p_last     = (p_q == cur_len - LW'(1));
		stat.p_more     = ((LW+1)'(p_q) + (LW+1)'(1)) < (LW+1)'(cur_len);
		stat.sh_more    = ((LW+1)'(p_q) + (LW+1)'(2)) < (LW+1)'(cur_len);
		stat.drop_hit   = drop_hit;
		stat.n_done     = (n_q == total_q);
	end

	// memory port and result selection
	always_comb begin
		rd_en = 1'b0;
		raddr = '0;
		wr_en = 1'b0;
		waddr = '0;
		wdata = rdata_q;
		emit  = 1'b0;
		res_d = '0;
		res_d.status = ST_OK;
		case (ctl.op)
			OP_APPEND: begin
				wr_en = 1'b1;
				waddr = qaddr(s_q, cur_front, cur_len);
				wdata = tid_q;
				emit  = 1'b1;
				res_d.caller_sleeps = (cur_len != '0);
				res_d.last = 1'b1;
			end
			OP_EMIT: begin
				emit = 1'b1;
				res_d.status = ctl.status;
				res_d.last = 1'b1;
			end
			OP_DROP_FIN: begin
				emit = 1'b1;
				res_d.last = 1'b1;
			end
			OP_LV_RD: begin
				rd_en = 1'b1;
				raddr = qaddr(s_q, cur_front, p_q);
			end
			OP_RO_RD, OP_HD_RD, OP_SW_RH: begin
				rd_en = 1'b1;
				raddr = qaddr(s_q, cur_front, '0);
			end
			OP_RO_WR: begin
				wr_en = 1'b1;
				waddr = qaddr(s_q, cur_front, cur_len - LW'(1));
			end
			OP_SH_RD: begin
				rd_en = 1'b1;
				raddr = qaddr(s_q, cur_front, p_q + LW'(1));
			end
			OP_SH_WR: begin
				wr_en = 1'b1;
				waddr = qaddr(s_q, cur_front, p_q);
			end
			OP_HD_EMIT: begin
				emit = 1'b1;
				res_d.wake_valid = 1'b1;
				res_d.wake_tid = rdata_q;
				res_d.last = 1'b1;
			end
			OP_SW_R2: begin
				rd_en = 1'b1;
				raddr = qaddr(s_q, cur_front, LW'(1));
			end
			OP_SW_CHK: begin
				emit = sw_wake && pend_q;
				res_d.wake_valid = 1'b1;
				res_d.wake_tid = pend_tid_q;
			end
			OP_SW2_RD: begin
				rd_en = 1'b1;
				raddr = qaddr(s_q, cur_front, cur_len - LW'(1));
			end
			OP_SW_END: begin
				emit = 1'b1;
				res_d.wake_valid = pend_q;
				res_d.wake_tid = pend_q ? pend_tid_q : '0;
				res_d.caller_sleeps = !runs_q;
				res_d.last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control state of the tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			newest_q  <= '0;
			total_q   <= '0;
			sidx_q    <= '0;
			s_q       <= '0;
			free_q    <= '0;
			found_q   <= 1'b0;
			free_ok_q <= 1'b0;
			p_q       <= '0;
			n_q       <= '0;
			pend_q    <= 1'b0;
			runs_q    <= 1'b0;
			rvalid_q  <= 1'b0;
			for (int i = 0; i < CONTAINERS; i++) begin
				front_q[i] <= '0;
				len_q[i]   <= '0;
			end
		end else begin
			rvalid_q <= emit;
			case (ctl.op)
				OP_LOAD: begin
					sidx_q    <= '0;
					found_q   <= 1'b0;
					free_ok_q <= 1'b0;
					p_q       <= '0;
				end
				OP_SCAN: begin
					if (used_q[sidx_q] && key_tab_q[sidx_q] == key_q && !found_q) begin
						found_q <= 1'b1;
						s_q     <= sidx_q;
					end
					if (!used_q[sidx_q] && !free_ok_q) begin
						free_ok_q <= 1'b1;
						free_q    <= sidx_q;
					end
					sidx_q <= sidx_q + SW'(1);
				end
				OP_ALLOC: begin
					used_q[free_q]  <= 1'b1;
					front_q[free_q] <= '0;
					len_q[free_q]   <= '0;
					newest_q        <= free_q;
					total_q         <= total_q + NW'(1);
					s_q             <= free_q;
				end
				OP_APPEND: len_q[s_q] <= cur_len + LW'(1);
				OP_LV_RD:  sidx_q <= '0;
				OP_LV_CMP: begin
					if (rdata_q != tid_q) p_q <= p_q + LW'(1);
				end
				OP_DROP_SCAN: begin
					if (drop_hit && newest_q == s_q) newest_q <= sidx_q;
					sidx_q <= sidx_q + SW'(1);
				end
				OP_DROP_FIN: begin
					if (total_q <= NW'(1)) begin
						total_q  <= '0;
						newest_q <= '0;
					end else begin
						total_q <= total_q - NW'(1);
					end
					used_q[s_q]  <= 1'b0;
					len_q[s_q]   <= '0;
					front_q[s_q] <= '0;
				end
				OP_RO_WR: begin
					front_q[s_q] <= finc;
					len_q[s_q]   <= cur_len - LW'(1);
				end
				OP_SH_WR:   p_q <= p_q + LW'(1);
				OP_LEN_DEC: len_q[s_q] <= cur_len - LW'(1);
				OP_SW_INIT: begin
					s_q    <= newest_q;
					n_q    <= '0;
					pend_q <= 1'b0;
					runs_q <= 1'b0;
				end
				OP_SW_CHK: begin
					if (sw_wake) begin
						pend_q       <= 1'b1;
						front_q[s_q] <= finc;
					end
					s_q <= next_q[s_q];
					n_q <= n_q + NW'(1);
				end
				OP_SW_ADV: begin
					s_q <= next_q[s_q];
					n_q <= n_q + NW'(1);
				end
				OP_SW2_INIT: begin
					s_q <= newest_q;
					n_q <= '0;
				end
				OP_SW2_CHK: begin
					if (rdata_q == tid_q) runs_q <= 1'b1;
					s_q <= next_q[s_q];
					n_q <= n_q + NW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// payload: request copy, keys, ring links, switch scratch ids, queue memory and its read data, result register
	always_ff @(posedge clk) begin
		if (ctl.op == OP_LOAD) begin
			cmd_q <= request.command;
			key_q <= request.container_id;
			tid_q <= request.caller_tid;
		end
		if (ctl.op == OP_ALLOC) begin
			key_tab_q[free_q] <= key_q;
			if (total_q == '0) begin
				next_q[free_q] <= free_q;
			end else begin
				next_q[free_q]   <= next_q[newest_q];
				next_q[newest_q] <= free_q;
			end
		end
		if (ctl.op == OP_DROP_SCAN && drop_hit) next_q[sidx_q] <= next_q[s_q];
		if (ctl.op == OP_SW_R2) head_q <= rdata_q;
		if (ctl.op == OP_SW_CHK && sw_wake) pend_tid_q <= rdata_q;
		if (wr_en) mem[waddr] <= wdata;
		if (rd_en) rdata_q <= mem[raddr];
		if (emit) result_q <= res_d;
	end

	assign result       = result_q;
	assign result_valid = rvalid_q;

endmodule

### src/grrs_ctrl.sv
// sequencing state machine of the scheduler
module grrs_ctrl import grrs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output ctl_t  ctl,
	output logic  busy
);

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_SCAN, S_DECIDE, S_APPEND, S_LV_RD, S_LV_CMP, S_NOTF,
		S_DROP_SCAN, S_DROP_FIN, S_RO_RD, S_RO_WR, S_SH_RD, S_SH_WR, S_LEN_DEC,
		S_HD_RD, S_HD_EMIT, S_SW_TOP, S_SW_R2, S_SW_CHK, S_SW2_TOP, S_SW2_CHK,
		S_SW_FIN
	} state_t;

	state_t state_q, nxt;
	logic   busy_q;

	always_comb begin
		nxt = state_q;
		ctl.op = OP_NONE;
		ctl.status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.op = OP_LOAD;
					nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.cmd == CMD_CREATE || stat.cmd == CMD_LEAVE) begin
					nxt = S_SCAN;
				end else if (stat.cmd == CMD_SWITCH && !stat.total_zero) begin
					ctl.op = OP_SW_INIT;
					nxt = S_SW_TOP;
				end else begin
					ctl.op = OP_EMIT;
					nxt = S_IDLE;
				end
			end
			S_SCAN: begin
				ctl.op = OP_SCAN;
				if (stat.scan_last) nxt = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.cmd == CMD_CREATE) begin
					nxt = S_IDLE;
					if (stat.found) begin
						if (stat.len_full) begin
							ctl.op = OP_EMIT;
							ctl.status = ST_QUEUE_FULL;
						end else begin
							ctl.op = OP_APPEND;
						end
					end else if (stat.total_full || !stat.free_ok) begin
						ctl.op = OP_EMIT;
						ctl.status = ST_TABLE_FULL;
					end else begin
						ctl.op = OP_ALLOC;
						nxt = S_APPEND;
					end
				end else if (!stat.found || stat.len_zero) begin
					ctl.op = OP_EMIT;
					ctl.status = ST_NOT_FOUND;
					nxt = S_IDLE;
				end else begin
					ctl.op = OP_LV_RD;
					nxt = S_LV_CMP;
				end
			end
			S_APPEND: begin
				ctl.op = OP_APPEND;
				nxt = S_IDLE;
			end
			S_LV_RD: begin
				ctl.op = OP_LV_RD;
				nxt = S_LV_CMP;
			end
			S_LV_CMP: begin
				ctl.op = OP_LV_CMP;
				if (stat.hit) begin
					if (stat.len_one) nxt = S_DROP_SCAN;
					else if (stat.p_last) nxt = S_RO_RD;
					else nxt = S_SH_RD;
				end else if (stat.p_more) begin
					nxt = S_LV_RD;
				end else begin
					nxt = S_NOTF;
				end
			end
			S_NOTF: begin
				ctl.op = OP_EMIT;
				ctl.status = ST_NOT_FOUND;
				nxt = S_IDLE;
			end
			S_DROP_SCAN: begin
				ctl.op = OP_DROP_SCAN;
				if (stat.drop_hit || stat.scan_last) nxt = S_DROP_FIN;
			end
			S_DROP_FIN: begin
				ctl.op = OP_DROP_FIN;
				nxt = S_IDLE;
			end
			S_RO_RD: begin
				ctl.op = OP_RO_RD;
				nxt = S_RO_WR;
			end
			S_RO_WR: begin
				ctl.op = OP_RO_WR;
				nxt = S_HD_RD;
			end
			S_SH_RD: begin
				ctl.op = OP_SH_RD;
				nxt = S_SH_WR;
			end
			S_SH_WR: begin
				ctl.op = OP_SH_WR;
				nxt = stat.sh_more ? S_SH_RD : S_LEN_DEC;
			end
			S_LEN_DEC: begin
				ctl.op = OP_LEN_DEC;
				nxt = S_HD_RD;
			end
			S_HD_RD: begin
				ctl.op = OP_HD_RD;
				nxt = S_HD_EMIT;
			end
			S_HD_EMIT: begin
				ctl.op = OP_HD_EMIT;
				nxt = S_IDLE;
			end
			S_SW_TOP: begin
				if (stat.n_done) begin
					ctl.op = OP_SW2_INIT;
					nxt = S_SW2_TOP;
				end else if (stat.len_ge2) begin
					ctl.op = OP_SW_RH;
					nxt = S_SW_R2;
				end else begin
					ctl.op = OP_SW_ADV;
				end
			end
			S_SW_R2: begin
				ctl.op = OP_SW_R2;
				nxt = S_SW_CHK;
			end
			S_SW_CHK: begin
				ctl.op = OP_SW_CHK;
				nxt = S_SW_TOP;
			end
			S_SW2_TOP: begin
				if (stat.n_done) begin
					ctl.op = OP_SW_END;
					nxt = S_IDLE;
				end else if (stat.len_zero) begin
					ctl.op = OP_SW_ADV;
				end else begin
					ctl.op = OP_SW2_RD;
					nxt = S_SW2_CHK;
				end
			end
			S_SW2_CHK: begin
				ctl.op = OP_SW2_CHK;
				nxt = stat.hit ? S_SW_FIN : S_SW2_TOP;
			end
			S_SW_FIN: begin
				ctl.op = OP_SW_END;
				nxt = S_IDLE;
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= nxt;
			busy_q  <= (nxt != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

### src/grouped_round_robin_task_scheduler.sv
// top level of the grouped round-robin task scheduler
// the time a request takes depends on C containers and T tasks per container
// and is set by the one-slot-a-cycle table scan
// and the single registered read port of the queue memory
// one request at a time; busy is high from the cycle after start until the last result
// reset (arst_n low) empties all containers at once; no clearing pass is needed
// results are shown for one cycle on result_valid; the receiver cannot stall
module grouped_round_robin_task_scheduler import grrs_pkg::*; #(
	parameter int CONTAINERS = CONTAINERS_DEF,
	parameter int TASKS      = TASKS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output res_t result,
	output logic result_valid
);

	// command from the sequencer and status back from the datapath
	ctl_t  ctl;
	stat_t stat;

	grrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	// tables, ring links and the queue memory live here
	grrs_datapath #(
		.CONTAINERS (CONTAINERS),
		.TASKS      (TASKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.request      (request),
		.ctl          (ctl),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

	// a result only comes out of work on an accepted request
	a_result_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result without request in work");

	// an accepted request raises busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");

	// error results end their request
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_OK |-> result.last)
		else $error("error result not last");

	// no wake id without a wake
	a_quiet_tid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.wake_valid |-> result.wake_tid == '0)
		else $error("wake id without wake");

endmodule

### tb/tb_grouped_round_robin_task_scheduler.sv
// self-checking testbench of the grouped round-robin task scheduler
module tb_grouped_round_robin_task_scheduler;
	import grrs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NC = CONTAINERS_DEF;
	localparam int NT = TASKS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 7 * NC + 40;
	localparam int N_DIRECTED = 20;
	localparam int N_RANDOM = 292;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	res_t result;
	logic result_valid;

	grouped_round_robin_task_scheduler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .result(result), .result_valid(result_valid)
	);

	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	// scheduler image kept by the predictor
	logic            used_q [NC];
	logic [KEY_W-1:0] key_q [NC];
	int              link_q [NC];
	int              newest_q;
	int              total_q;
	logic [TID_W-1:0] tasks_q [NC][NT];
	int              front_q [NC];
	int              len_q [NC];

	res_t wake_fifo [$];
	int   n_fail;
	int   cycles;
	logic no_idle;

	// directed stimulus, with a fixed result where it is obvious
	typedef struct {
		req_t req;
		logic known;
		res_t res;
	} row_t;
	row_t rows [N_DIRECTED];

	function automatic res_t mk(logic wv, logic [TID_W-1:0] wt, logic sl,
			logic [1:0] st, logic lst);
		res_t r;
		r.wake_valid = wv; r.wake_tid = wt; r.caller_sleeps = sl;
		r.status = st; r.last = lst;
		return r;
	endfunction

	function automatic int qidx(int s, int i);
		return (front_q[s] + i) % NT;
	endfunction

	function automatic int find_key(logic [KEY_W-1:0] k);
		for (int s = 0; s < NC; s++)
			if (used_q[s] && key_q[s] == k)
				return s;
		return -1;
	endfunction

	task automatic sched_reset();
		for (int s = 0; s < NC; s++) begin
			used_q[s] = 1'b0; front_q[s] = 0; len_q[s] = 0; link_q[s] = 0;
		end
		newest_q = 0; total_q = 0;
	endtask

	// update the image for one request and queue its results
	task automatic predict_request(req_t r);
		int s, p, ln, k;
		logic [TID_W-1:0] hd, sc;
		logic runs;
		res_t tmp;
		k = 0;
		runs = 1'b0;
		case (r.command)
		CMD_CREATE: begin
			s = find_key(r.container_id);
			if (s < 0) begin
				if (total_q >= NC) begin
					wake_fifo.push_back(mk(0, 0, 0, ST_TABLE_FULL, 1));
					return;
				end
				for (s = 0; s < NC && used_q[s]; s++) ;
				used_q[s] = 1'b1; key_q[s] = r.container_id;
				front_q[s] = 0; len_q[s] = 0;
				if (total_q == 0) begin
					link_q[s] = s;
				end else begin
					link_q[s] = link_q[newest_q];
					link_q[newest_q] = s;
				end
				newest_q = s;
				total_q++;
			end
			ln = len_q[s];
			if (ln >= NT) begin
				wake_fifo.push_back(mk(0, 0, 0, ST_QUEUE_FULL, 1));
				return;
			end
			tasks_q[s][qidx(s, ln)] = r.caller_tid;
			len_q[s] = ln + 1;
			wake_fifo.push_back(mk(0, 0, ln > 0, ST_OK, 1));
		end
		CMD_LEAVE: begin
			s = find_key(r.container_id);
			if (s < 0 || len_q[s] == 0) begin
				wake_fifo.push_back(mk(0, 0, 0, ST_NOT_FOUND, 1));
				return;
			end
			ln = len_q[s];
			for (p = 0; p < ln; p++)
				if (tasks_q[s][qidx(s, p)] == r.caller_tid)
					break;
			if (p >= ln) begin
				wake_fifo.push_back(mk(0, 0, 0, ST_NOT_FOUND, 1));
				return;
			end
			if (ln == 1) begin
				// last task leaves: unlink the container from the ring
				if (total_q <= 1) begin
					total_q = 0; newest_q = 0;
				end else begin
					for (int q = 0; q < NC; q++)
						if (used_q[q] && q != s && link_q[q] == s) begin
							link_q[q] = link_q[s];
							if (newest_q == s)
								newest_q = q;
							break;
						end
					total_q--;
				end
				used_q[s] = 1'b0; len_q[s] = 0; front_q[s] = 0;
				wake_fifo.push_back(mk(0, 0, 0, ST_OK, 1));
				return;
			end
			if (p == ln - 1) begin
				// back entry leaves: old head takes its place, queue rotates
				tasks_q[s][qidx(s, ln - 1)] = tasks_q[s][qidx(s, 0)];
				front_q[s] = (front_q[s] + 1) % NT;
			end else begin
				for (int i = p; i + 1 < ln; i++)
					tasks_q[s][qidx(s, i)] = tasks_q[s][qidx(s, i + 1)];
			end
			len_q[s] = ln - 1;
			wake_fifo.push_back(mk(1, tasks_q[s][qidx(s, 0)], 0, ST_OK, 1));
		end
		CMD_SWITCH: begin
			if (total_q == 0) begin
				wake_fifo.push_back(mk(0, 0, 0, ST_OK, 1));
				return;
			end
			s = newest_q;
			for (int n = 0; n < total_q; n++) begin
				if (len_q[s] >= 2) begin
					hd = tasks_q[s][qidx(s, 0)];
					sc = tasks_q[s][qidx(s, 1)];
					if (sc != hd && sc != r.caller_tid) begin
						wake_fifo.push_back(mk(1, sc, 0, ST_OK, 0));
						k++;
						front_q[s] = (front_q[s] + 1) % NT;
					end
				end
				s = link_q[s];
			end
			s = newest_q;
			for (int n = 0; n < total_q; n++) begin
				if (len_q[s] > 0 && tasks_q[s][qidx(s, len_q[s] - 1)] == r.caller_tid) begin
					runs = 1'b1;
					break;
				end
				s = link_q[s];
			end
			if (k == 0) begin
				wake_fifo.push_back(mk(0, 0, !runs, ST_OK, 1));
			end else begin
				tmp = wake_fifo.pop_back();
				tmp.caller_sleeps = !runs;
				tmp.last = 1'b1;
				wake_fifo.push_back(tmp);
			end
		end
		default: wake_fifo.push_back(mk(0, 0, 0, ST_OK, 1));
		endcase
	endtask

	// compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		res_t e;
		if (arst_n && result_valid) begin
			if (wake_fifo.size() == 0) begin
				$error("unexpected result %h", result);
				n_fail++;
			end else begin
				e = wake_fifo.pop_front();
				if (result.wake_valid !== e.wake_valid) begin
					$error("wake_valid exp %0d got %0d", e.wake_valid, result.wake_valid);
					n_fail++;
				end
				if (result.wake_tid !== e.wake_tid) begin
					$error("wake_tid exp %0h got %0h", e.wake_tid, result.wake_tid);
					n_fail++;
				end
				if (result.caller_sleeps !== e.caller_sleeps) begin
					$error("caller_sleeps exp %0d got %0d", e.caller_sleeps,
						result.caller_sleeps);
					n_fail++;
				end
				if (result.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, result.status);
					n_fail++;
				end
				if (result.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, result.last);
					n_fail++;
				end
			end
		end
	end

	// cycle watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// present one request, wait for its acceptance and then for its work to end
	task automatic issue_request(req_t r, logic known, res_t fixed);
		while (!no_idle && $urandom_range(99) < 12)
			@(posedge clk);
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// accepted at this edge
		predict_request(r);
		if (known) begin
			if (wake_fifo[$] !== fixed) begin
				$error("directed row result exp %h pred %h", fixed, wake_fifo[$]);
				n_fail++;
			end
		end
		start <= 1'b0;
		// busy rises the cycle after start
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	function automatic req_t rq(logic [1:0] c, logic [KEY_W-1:0] k, logic [TID_W-1:0] t);
		req_t r;
		r.command = c; r.container_id = k; r.caller_tid = t;
		return r;
	endfunction

	// random request: mostly a small pool of keys and tids to build deep queues
	function automatic req_t random_request(bit wide);
		req_t r;
		int pick;
		pick = $urandom_range(99);
		if (pick < 45)
			r.command = CMD_CREATE;
		else if (pick < 75)
			r.command = CMD_LEAVE;
		else if (pick < 97)
			r.command = CMD_SWITCH;
		else
			r.command = 2'd3;
		if (wide) begin
			r.container_id = $urandom;
			r.caller_tid = $urandom;
		end else begin
			r.container_id = $urandom_range(20) ^ ($urandom_range(1) ? 16'hffe0 : 16'h0);
			r.caller_tid = $urandom_range(12) ^ ($urandom_range(1) ? 22'h3ffff0 : 22'h0);
		end
		return r;
	endfunction

	initial begin
		res_t z;
		req_t r;
		n_fail = 0;
		cycles = 0;
		no_idle = 1'b0;
		start = 1'b0;
		request = '0;
		arst_n = 1'b0;
		sched_reset();
		z = '0;
		// empty switch, unknown leave, unknown command, extremes, duplicates
		rows[0]  = '{rq(CMD_SWITCH, 0, 22'h3fffff), 1, mk(0, 0, 0, ST_OK, 1)};
		rows[1]  = '{rq(CMD_LEAVE, 16'hffff, 0), 1, mk(0, 0, 0, ST_NOT_FOUND, 1)};
		rows[2]  = '{rq(2'd3, 16'hffff, 22'h3fffff), 1, mk(0, 0, 0, ST_OK, 1)};
		rows[3]  = '{rq(CMD_CREATE, 16'hffff, 22'h3fffff), 1, mk(0, 0, 0, ST_OK, 1)};
		rows[4]  = '{rq(CMD_CREATE, 16'hffff, 0), 1, mk(0, 0, 1, ST_OK, 1)};
		rows[5]  = '{rq(CMD_CREATE, 16'hffff, 22'h3fffff), 0, z};
		rows[6]  = '{rq(CMD_CREATE, 0, 5), 0, z};
		rows[7]  = '{rq(CMD_CREATE, 0, 6), 0, z};
		rows[8]  = '{rq(CMD_SWITCH, 0, 7), 0, z};
		rows[9]  = '{rq(CMD_SWITCH, 0, 22'h3fffff), 0, z};
		rows[10] = '{rq(CMD_LEAVE, 16'hffff, 1), 1, mk(0, 0, 0, ST_NOT_FOUND, 1)};
		rows[11] = '{rq(CMD_LEAVE, 16'hffff, 22'h3fffff), 0, z};
		rows[12] = '{rq(CMD_LEAVE, 0, 6), 0, z};
		rows[13] = '{rq(CMD_LEAVE, 0, 5), 0, z};
		rows[14] = '{rq(CMD_LEAVE, 0, 6), 0, z};
		rows[15] = '{rq(CMD_LEAVE, 0, 5), 1, mk(0, 0, 0, ST_NOT_FOUND, 1)};
		rows[16] = '{rq(CMD_CREATE, 16'h1234, 22'h2aaaaa), 0, z};
		rows[17] = '{rq(CMD_SWITCH, 0, 22'h155555), 0, z};
		rows[18] = '{rq(CMD_LEAVE, 16'h1234, 22'h2aaaaa), 0, z};
		rows[19] = '{rq(CMD_SWITCH, 16'hffff, 0), 0, z};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			issue_request(rows[i].req, rows[i].known, rows[i].res);
		// fill the table and one queue to hit both full codes
		for (int i = 0; i < NC + 1; i++)
			issue_request(rq(CMD_CREATE, 16'h8000 + i, i), 0, z);
		for (int i = 0; i < NT + 1; i++)
			issue_request(rq(CMD_CREATE, 16'h8000, 22'h100 + i), 0, z);
		issue_request(rq(CMD_SWITCH, 0, 0), 0, z);
		for (int i = 0; i < NT + 1; i++)
			issue_request(rq(CMD_LEAVE, 16'h8000, 22'h100 + i), 0, z);
		for (int i = 0; i < NC; i++)
			issue_request(rq(CMD_LEAVE, 16'h8000 + i, i), 0, z);
		// random part, with a stretch run back to back
		for (int i = 0; i < N_RANDOM; i++) begin
			no_idle = (i >= 150 && i < 230);
			r = random_request($urandom_range(9) == 0);
			issue_request(r, 0, z);
		end
		no_idle = 1'b0;
		while (wake_fifo.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0 && wake_fifo.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
